[rtl/fbr_pkg.sv]
// ---------------------------------------------------------------------------
// fbr_pkg
// Shared types and constants of the page framebuffer with refresh stream.
// ---------------------------------------------------------------------------
package fbr_pkg;

    localparam int CMD_W  = 3;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int BYTE_W = 8;
    // row bits that select the bit inside a byte
    localparam int BIT_W  = 3;
    // width of a page number taken from a row
    localparam int PGIN_W = ROW_W - BIT_W;

    localparam logic [CMD_W-1:0] CMD_WRITE_PIXEL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FILL_RECT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REFRESH     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_BYTE   = 3'd4;

    localparam logic [BYTE_W-1:0] PAGE_CMD_BASE = 8'hB0;
    localparam logic [BYTE_W-1:0] COL_LOW_CMD   = 8'h00;
    localparam logic [BYTE_W-1:0] COL_HIGH_CMD  = 8'h10;
    localparam int                PREAMBLE      = 3;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PRD   = 8'b0000_0100,
        S_PWR   = 8'b0000_1000,
        S_ORD   = 8'b0001_0000,
        S_RESP  = 8'b0010_0000,
        S_FRD   = 8'b0100_0000,
        S_FWR   = 8'b1000_0000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // item transfer on the input channel
        logic clr_we;    // write zero at the sweep address, advance sweep
        logic pix_we;    // write back the modified pixel byte
        logic fill_we;   // write back the filled byte, advance fill walk
        logic out_load;  // capture the result into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic fill_last;
        logic fill_empty;
        logic pix_off;
        logic out_busy;
    } t_dp_stat;

endpackage

[rtl/fbr_ram.sv]
// ---------------------------------------------------------------------------
// fbr_ram
// Generic single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module fbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fbr_ctrl.sv]
// ---------------------------------------------------------------------------
// fbr_ctrl
// Sequencer: clearing sweep, pixel read-modify-write, rectangle fill walk,
// and result delivery.
// ---------------------------------------------------------------------------
module fbr_ctrl import fbr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_ready,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_cmd)
                        CMD_WRITE_PIXEL: n_state = i_stat.pix_off ? S_IDLE : S_PRD;
                        CMD_FILL_RECT:   n_state = i_stat.fill_empty ? S_IDLE : S_FRD;
                        CMD_CLEAR_ALL:   n_state = S_CLEAR;
                        CMD_REFRESH:     n_state = S_ORD;
                        CMD_READ_BYTE:   n_state = S_ORD;
                        default:         n_state = S_IDLE;
                    endcase
                end
            end
            S_PRD:  n_state = S_PWR;
            S_PWR:  n_state = S_IDLE;
            S_ORD:  n_state = S_RESP;
            S_RESP: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            S_FRD:  n_state = S_FWR;
            S_FWR:  n_state = i_stat.fill_last ? S_IDLE : S_FRD;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.clr_we   = (r_state == S_CLEAR);
        o_cmd.pix_we   = (r_state == S_PWR);
        o_cmd.fill_we  = (r_state == S_FWR);
        o_cmd.out_load = (r_state == S_RESP) && !i_stat.out_busy;
    end

endmodule

[rtl/fbr_dp.sv]
// ---------------------------------------------------------------------------
// fbr_dp
// Datapath: item latch, frame address, refresh counters, byte modify logic,
// frame RAM and output register.
// ---------------------------------------------------------------------------
module fbr_dp import fbr_pkg::*; #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [CMD_W-1:0]  i_item_cmd,
    input  logic [COL_W-1:0]  i_col_a,
    input  logic [ROW_W-1:0]  i_row_a,
    input  logic [COL_W-1:0]  i_col_b,
    input  logic [ROW_W-1:0]  i_row_b,
    input  logic              i_pixel_on,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_data,
    output logic              o_frame_end
);

    localparam int DEPTH  = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $clog2(SCREEN_COLUMNS);
    localparam int PW     = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
    localparam int RPW    = $clog2(SCREEN_COLUMNS + PREAMBLE);
    localparam int CXW    = ((COL_W > CW) ? COL_W : CW) + 1;
    localparam int PXW    = ((PGIN_W > PW) ? PGIN_W : PW) + 1;

    localparam logic [CXW-1:0]    COL_LAST_X = CXW'(SCREEN_COLUMNS - 1);
    localparam logic [PXW-1:0]    PG_LAST_X  = PXW'(SCREEN_PAGES - 1);
    localparam logic [PW-1:0]     PG_LAST    = PW'(SCREEN_PAGES - 1);
    localparam logic [RPW-1:0]    POS_LAST   = RPW'(SCREEN_COLUMNS + PREAMBLE - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(DEPTH - 1);

    // input decode, used at transfer time
    logic [CXW-1:0] col_a_x, col_b_x, col_end_x;
    logic [PXW-1:0] pg_a_x, pg_b_x, pg_end_x;
    logic           col_a_off, pg_a_off;

    assign col_a_x   = CXW'(i_col_a);
    assign col_b_x   = CXW'(i_col_b);
    assign pg_a_x    = PXW'(i_row_a[ROW_W-1:BIT_W]);
    assign pg_b_x    = PXW'(i_row_b[ROW_W-1:BIT_W]);
    assign col_end_x = (col_b_x > COL_LAST_X) ? COL_LAST_X : col_b_x;
    assign pg_end_x  = (pg_b_x > PG_LAST_X) ? PG_LAST_X : pg_b_x;
    assign col_a_off = (col_a_x > COL_LAST_X);
    assign pg_a_off  = (pg_a_x > PG_LAST_X);

    // latched item
    logic [CMD_W-1:0]  r_cmd;
    logic [CW-1:0]     r_col_a, r_col_end;
    logic [PW-1:0]     r_pg_end;
    logic [PXW-1:0]    r_pg_a_x, r_pg_b_x;
    logic [BIT_W-1:0]  r_bit_a, r_bit_b;
    logic              r_on, r_rd_off;
    logic [RPW-1:0]    r_pos_snap;

    // walking address and clearing sweep
    logic [CW-1:0]     r_col;
    logic [PW-1:0]     r_pg;
    logic [ADDR_W-1:0] r_clr;

    // refresh counters
    logic [PW-1:0]     r_rpg;
    logic [RPW-1:0]    r_rpos;

    // output register
    logic              r_o_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_is_data, r_frame_end;

    logic [ADDR_W-1:0] walk_addr, ram_addr;
    logic [BYTE_W-1:0] rdata, wdata, pix_bit, fill_mask;
    logic [BIT_W-1:0]  lo, hi;
    logic              ram_we;
    logic [BYTE_W-1:0] res_byte;
    logic              res_data, res_end;

    assign walk_addr = ADDR_W'(32'(r_pg) * 32'(SCREEN_COLUMNS) + 32'(r_col));
    assign ram_addr  = i_cmd.clr_we ? r_clr : walk_addr;
    assign ram_we    = i_cmd.clr_we | i_cmd.pix_we | i_cmd.fill_we;

    assign pix_bit = BYTE_W'(1) << r_bit_a;
    assign lo      = (PXW'(r_pg) == r_pg_a_x) ? r_bit_a : '0;
    assign hi      = (PXW'(r_pg) == r_pg_b_x) ? r_bit_b : '1;
    assign fill_mask = ({BYTE_W{1'b1}} << lo) & ({BYTE_W{1'b1}} >> (3'd7 - hi));

    always_comb begin
        wdata = '0;
        if (i_cmd.pix_we) begin
            wdata = r_on ? (rdata | pix_bit) : (rdata & ~pix_bit);
        end else if (i_cmd.fill_we) begin
            wdata = rdata | fill_mask;
        end
    end

    fbr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    // status
    assign o_stat.clr_last   = (r_clr == ADDR_LAST);
    assign o_stat.fill_last  = (r_col == r_col_end) && (r_pg == r_pg_end);
    assign o_stat.fill_empty = (i_col_a > i_col_b) || (i_row_a > i_row_b) ||
                               col_a_off || pg_a_off;
    assign o_stat.pix_off    = col_a_off || pg_a_off;
    assign o_stat.out_busy   = r_o_valid && !i_ready;

    // item latch and walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_item_cmd;
            r_col_a    <= CW'(i_col_a);
            r_col_end  <= CW'(col_end_x);
            r_pg_end   <= PW'(pg_end_x);
            r_pg_a_x   <= pg_a_x;
            r_pg_b_x   <= pg_b_x;
            r_bit_a    <= i_row_a[BIT_W-1:0];
            r_bit_b    <= i_row_b[BIT_W-1:0];
            r_on       <= i_pixel_on;
            r_rd_off   <= col_a_off || pg_a_off;
            r_pos_snap <= r_rpos;
            if (i_item_cmd == CMD_REFRESH) begin
                r_pg  <= r_rpg;
                r_col <= CW'(r_rpos - RPW'(PREAMBLE));
            end else begin
                r_pg  <= PW'(pg_a_x);
                r_col <= CW'(i_col_a);
            end
        end else if (i_cmd.fill_we) begin
            if (r_col == r_col_end) begin
                r_col <= r_col_a;
                r_pg  <= r_pg + PW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // clearing sweep and refresh counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_rpg  <= '0;
            r_rpos <= '0;
        end else begin
            if (i_cmd.load) begin
                r_clr <= '0;
            end else if (i_cmd.clr_we) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd.load && (i_item_cmd == CMD_REFRESH)) begin
                if (r_rpos == POS_LAST) begin
                    r_rpos <= '0;
                    r_rpg  <= (r_rpg == PG_LAST) ? '0 : r_rpg + PW'(1);
                end else begin
                    r_rpos <= r_rpos + RPW'(1);
                end
            end
        end
    end

    // result select
    always_comb begin
        res_byte = rdata;
        res_data = 1'b0;
        res_end  = 1'b0;
        if (r_cmd == CMD_REFRESH) begin
            case (r_pos_snap)
                RPW'(0): res_byte = PAGE_CMD_BASE + BYTE_W'(r_pg);
                RPW'(1): res_byte = COL_LOW_CMD;
                RPW'(2): res_byte = COL_HIGH_CMD;
                default: begin
                    res_byte = rdata;
                    res_data = 1'b1;
                    res_end  = (r_pg == PG_LAST) && (r_pos_snap == POS_LAST);
                end
            endcase
        end else if (r_rd_off) begin
            res_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte  <= res_byte;
            r_is_data   <= res_data;
            r_frame_end <= res_end;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_data   = r_is_data;
    assign o_frame_end = r_frame_end;

endmodule

[rtl/page_framebuffer_with_refresh.sv]
// ---------------------------------------------------------------------------
// page_framebuffer_with_refresh
// Page-organized monochrome frame store with a display refresh byte stream.
// ---------------------------------------------------------------------------
// The store holds SCREEN_COLUMNS x SCREEN_PAGES bytes in one single-port RAM;
// bit (row % 8) of byte (column, row / 8) is the pixel. One command is worked
// at a time and every frame access goes through the one RAM port: a pixel
// write is a transfer, a read and a write back; a read or refresh command is
// a transfer, a read and a load of the output register; a rectangle fill is
// a transfer and then a read and a write back per touched byte; a clear-all
// is a transfer and then a write of zero to each of the SCREEN_COLUMNS *
// SCREEN_PAGES bytes (1024 at the default size). After reset the same
// clearing pass runs with o_ready low. A result sits in the output register
// until transferred; the next command is taken while it waits, and only a
// second result command stalls behind it. Each refresh page is the command
// bytes 0xB0 + page, 0x00, 0x10 and then its data bytes in column order;
// o_frame_end flags the last data byte of the last page.
// ---------------------------------------------------------------------------
module page_framebuffer_with_refresh import fbr_pkg::*; #(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [COL_W-1:0]  i_col_a,
    input  logic [ROW_W-1:0]  i_row_a,
    input  logic [COL_W-1:0]  i_col_b,
    input  logic [ROW_W-1:0]  i_row_b,
    input  logic              i_pixel_on,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_is_data,
    output logic              o_frame_end
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequence the RAM port: sweep, read-modify-write, fill walk, result load
    fbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // hold the item, compute addresses and masks, keep the refresh position
    fbr_dp #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_item_cmd  (i_cmd),
        .i_col_a     (i_col_a),
        .i_row_a     (i_row_a),
        .i_col_b     (i_col_b),
        .i_row_b     (i_row_b),
        .i_pixel_on  (i_pixel_on),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_is_data   (o_is_data),
        .o_frame_end (o_frame_end)
    );

endmodule
